[hw/rtl/elp_pkg.sv]
package elp_pkg;

  localparam int unsigned VALUES_KEPT = 3;
  localparam int unsigned KEPT_IDX_W = (VALUES_KEPT > 1) ? $clog2(VALUES_KEPT) : 1;
  localparam int unsigned THIRD_IDX = (VALUES_KEPT > 2) ? 2 : 0;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned PROD_W = VALUE_W + 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] RECORD_MIN = COUNT_W'(2);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_END = 2'd1,
    KIND_OVERFLOW = 2'd2,
    KIND_NEGATIVE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_START,
    PHASE_DATA,
    PHASE_COMMENT
  } phase_t;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_BLANK,
    CLS_EOL,
    CLS_COMMENT,
    CLS_MINUS,
    CLS_OTHER,
    CLS_EOI
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic [3:0] digit;
  } tok_t;

endpackage

[hw/rtl/elp_if.sv]
interface elp_in_if;
  logic valid;
  logic ready;
  logic [7:0] byte_req;
  logic end_of_input;

  modport source (output valid, output byte_req, output end_of_input, input ready);
  modport sink (input valid, input byte_req, input end_of_input, output ready);
endinterface

interface elp_out_if;
  logic valid;
  logic ready;
  elp_pkg::kind_t kind;
  logic [elp_pkg::VALUE_W-1:0] first;
  logic [elp_pkg::VALUE_W-1:0] second;
  logic [elp_pkg::VALUE_W-1:0] third;
  logic [elp_pkg::COUNT_W-1:0] number_count;
  logic last;

  modport source (output valid, output kind, output first, output second, output third,
                  output number_count, output last, input ready);
  modport sink (input valid, input kind, input first, input second, input third,
                input number_count, input last, output ready);
endinterface

[hw/rtl/edge_list_line_number_parser.sv]
// A byte is written into the front-end queue, then popped by the back end, which registers
// its result in the output register. Throughput: one byte per cycle while the queue has
// room and the output is taken; an end-of-input transaction that closes a pending data line
// gives the record, then the end result. The back end's per-byte multiply-by-ten and add is combinational.
// Reset (rst, synchronous, active high) empties the queue, returns the parser to line
// start with all values cleared and drops any result not yet taken.
module edge_list_line_number_parser (
  input  logic clk,
  input  logic rst,
  elp_in_if.sink rx,
  elp_out_if.source tx
);

  // Token handoff from the classifier front end to the parser back end.
  logic tok_valid;
  elp_pkg::tok_t tok;
  logic tok_pop;

  // Front end: classify each byte (digit, blank, end of line, comment mark, minus,
  // other, end of input) and hold it in a short queue so that input and output
  // stall independently.
  elp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop)
  );

  // Back end: advance the line state, accumulate digits, keep the first numbers of
  // the line, and load the output register. It pops a token whenever the output
  // register is empty or being drained, save an end-of-input token held for a record,
  // so a waiting result never blocks the queue for longer than the consumer holds it.
  elp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .tx        (tx)
  );

endmodule

[hw/rtl/elp_front.sv]
module elp_front (
  input  logic clk,
  input  logic rst,
  elp_in_if.sink rx,
  output logic tok_valid,
  output elp_pkg::tok_t tok,
  input  logic tok_pop
);

  elp_pkg::tok_t queue [elp_pkg::QUEUE_DEPTH];
  logic [elp_pkg::QPTR_W-1:0] wr_ptr;
  logic [elp_pkg::QPTR_W-1:0] rd_ptr;
  logic [elp_pkg::QCNT_W-1:0] count;
  elp_pkg::tok_t in_tok;
  logic push;

  // Classify the byte.
  always_comb begin
    in_tok.digit = rx.byte_req[3:0];
    if (rx.end_of_input) begin
      in_tok.cls = elp_pkg::CLS_EOI;
    end else if (rx.byte_req >= elp_pkg::CHAR_ZERO && rx.byte_req <= elp_pkg::CHAR_NINE) begin
      in_tok.cls = elp_pkg::CLS_DIGIT;
    end else if (rx.byte_req == elp_pkg::CHAR_LF || rx.byte_req == elp_pkg::CHAR_CR) begin
      in_tok.cls = elp_pkg::CLS_EOL;
    end else if (rx.byte_req == elp_pkg::CHAR_SPACE || rx.byte_req == elp_pkg::CHAR_TAB) begin
      in_tok.cls = elp_pkg::CLS_BLANK;
    end else if (rx.byte_req == elp_pkg::CHAR_HASH || rx.byte_req == elp_pkg::CHAR_PERCENT) begin
      in_tok.cls = elp_pkg::CLS_COMMENT;
    end else if (rx.byte_req == elp_pkg::CHAR_MINUS) begin
      in_tok.cls = elp_pkg::CLS_MINUS;
    end else begin
      in_tok.cls = elp_pkg::CLS_OTHER;
    end
  end

  assign rx.ready = (count != elp_pkg::QCNT_W'(elp_pkg::QUEUE_DEPTH));
  assign push = rx.valid && rx.ready;
  assign tok_valid = (count != '0);
  assign tok = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == elp_pkg::QPTR_W'(elp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (tok_pop) begin
        rd_ptr <= (rd_ptr == elp_pkg::QPTR_W'(elp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + elp_pkg::QCNT_W'(push) - elp_pkg::QCNT_W'(tok_pop);
    end
  end

endmodule

[hw/rtl/elp_back.sv]
module elp_back (
  input  logic clk,
  input  logic rst,
  input  logic tok_valid,
  input  elp_pkg::tok_t tok,
  output logic tok_pop,
  elp_out_if.source tx
);

  localparam int unsigned VW = elp_pkg::VALUE_W;
  localparam int unsigned CW = elp_pkg::COUNT_W;
  localparam int unsigned NK = elp_pkg::VALUES_KEPT;

  elp_pkg::phase_t phase, phase_next;
  logic [VW-1:0] acc, acc_next;
  logic in_num, in_num_next;
  logic [CW-1:0] seen, seen_next;
  logic [VW-1:0] kept [NK];
  logic [VW-1:0] kept_next [NK];
  logic err, err_next;
  logic pend_end, pend_end_next;

  logic out_valid;
  elp_pkg::kind_t out_kind;
  logic [VW-1:0] out_first, out_second, out_third;
  logic [CW-1:0] out_count;
  logic out_last;

  logic [VW-1:0] closed_kept [NK];
  logic [CW-1:0] closed_seen;
  logic [elp_pkg::PROD_W-1:0] prod;
  logic out_free;
  logic emit, emit_vals, emit_last;
  elp_pkg::kind_t emit_kind;

  assign out_free = !out_valid || tx.ready;

  // Close the pending number without committing it.
  always_comb begin
    for (int i = 0; i < NK; i++) begin
      closed_kept[i] = (in_num && seen == CW'(i)) ? acc : kept[i];
    end
    closed_seen = (in_num && seen != elp_pkg::COUNT_MAX) ? seen + 1'b1 : seen;
    prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + elp_pkg::PROD_W'(tok.digit);
  end

  always_comb begin
    phase_next = phase;
    acc_next = acc;
    in_num_next = in_num;
    seen_next = seen;
    kept_next = kept;
    err_next = err;
    pend_end_next = pend_end;
    emit = 1'b0;
    emit_vals = 1'b0;
    emit_last = 1'b0;
    emit_kind = elp_pkg::KIND_END;
    tok_pop = 1'b0;

    if (tok_valid && out_free) begin
      tok_pop = 1'b1;
      if (tok.cls == elp_pkg::CLS_EOI) begin
        if (!err && phase == elp_pkg::PHASE_DATA && closed_seen >= elp_pkg::RECORD_MIN
            && !pend_end) begin
          // Hold the token: the end transaction follows once the output register is free.
          tok_pop = 1'b0;
          emit = 1'b1;
          emit_vals = 1'b1;
          emit_kind = elp_pkg::KIND_RECORD;
          pend_end_next = 1'b1;
        end else begin
          emit = 1'b1;
          emit_last = 1'b1;
          emit_kind = elp_pkg::KIND_END;
          phase_next = elp_pkg::PHASE_START;
          acc_next = '0;
          in_num_next = 1'b0;
          seen_next = '0;
          for (int i = 0; i < NK; i++) begin
            kept_next[i] = '0;
          end
          err_next = 1'b0;
          pend_end_next = 1'b0;
        end
      end else if (err) begin
        // Drop bytes after an error.
      end else if (phase == elp_pkg::PHASE_COMMENT) begin
        if (tok.cls == elp_pkg::CLS_EOL) begin
          phase_next = elp_pkg::PHASE_START;
        end
      end else if (phase == elp_pkg::PHASE_START &&
                   (tok.cls == elp_pkg::CLS_EOL || tok.cls == elp_pkg::CLS_BLANK)) begin
        // Skip leading whitespace.
      end else if (phase == elp_pkg::PHASE_START && tok.cls == elp_pkg::CLS_COMMENT) begin
        phase_next = elp_pkg::PHASE_COMMENT;
      end else begin
        phase_next = elp_pkg::PHASE_DATA;
        if (tok.cls == elp_pkg::CLS_DIGIT) begin
          if (prod[elp_pkg::PROD_W-1:VW] != '0) begin
            err_next = 1'b1;
            emit = 1'b1;
            emit_last = 1'b1;
            emit_kind = elp_pkg::KIND_OVERFLOW;
          end else begin
            acc_next = prod[VW-1:0];
            in_num_next = 1'b1;
          end
        end else begin
          kept_next = closed_kept;
          seen_next = closed_seen;
          acc_next = '0;
          in_num_next = 1'b0;
          if (tok.cls == elp_pkg::CLS_MINUS) begin
            err_next = 1'b1;
            emit = 1'b1;
            emit_last = 1'b1;
            emit_kind = elp_pkg::KIND_NEGATIVE;
          end else if (tok.cls == elp_pkg::CLS_EOL) begin
            if (closed_seen >= elp_pkg::RECORD_MIN) begin
              emit = 1'b1;
              emit_vals = 1'b1;
              emit_last = 1'b1;
              emit_kind = elp_pkg::KIND_RECORD;
            end
            seen_next = '0;
            for (int i = 0; i < NK; i++) begin
              kept_next[i] = '0;
            end
            phase_next = elp_pkg::PHASE_START;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= elp_pkg::PHASE_START;
      acc <= '0;
      in_num <= 1'b0;
      seen <= '0;
      for (int i = 0; i < NK; i++) begin
        kept[i] <= '0;
      end
      err <= 1'b0;
      pend_end <= 1'b0;
    end else begin
      phase <= phase_next;
      acc <= acc_next;
      in_num <= in_num_next;
      seen <= seen_next;
      kept <= kept_next;
      err <= err_next;
      pend_end <= pend_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= emit_kind;
      out_last <= emit_last;
      out_first <= emit_vals ? closed_kept[0] : '0;
      out_second <= emit_vals ? closed_kept[1] : '0;
      out_third <= (emit_vals && NK > 2) ? closed_kept[elp_pkg::THIRD_IDX] : '0;
      out_count <= emit_vals ? closed_seen : '0;
    end
  end

  assign tx.valid = out_valid;
  assign tx.kind = out_kind;
  assign tx.first = out_first;
  assign tx.second = out_second;
  assign tx.third = out_third;
  assign tx.number_count = out_count;
  assign tx.last = out_last;

endmodule
